>>> rtl/core/alu8f_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alu8f_pkg;

  localparam int KIND_W = 5;
  localparam int DATA_W = 8;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_ADD  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_ADC  = 5'd1;
  localparam logic [KIND_W-1:0] KIND_SUB  = 5'd2;
  localparam logic [KIND_W-1:0] KIND_SBC  = 5'd3;
  localparam logic [KIND_W-1:0] KIND_AND  = 5'd4;
  localparam logic [KIND_W-1:0] KIND_OR   = 5'd5;
  localparam logic [KIND_W-1:0] KIND_XOR  = 5'd6;
  localparam logic [KIND_W-1:0] KIND_CP   = 5'd7;
  localparam logic [KIND_W-1:0] KIND_INC  = 5'd8;
  localparam logic [KIND_W-1:0] KIND_DEC  = 5'd9;
  localparam logic [KIND_W-1:0] KIND_RLCA = 5'd10;
  localparam logic [KIND_W-1:0] KIND_RRCA = 5'd11;
  localparam logic [KIND_W-1:0] KIND_RLA  = 5'd12;
  localparam logic [KIND_W-1:0] KIND_RRA  = 5'd13;
  localparam logic [KIND_W-1:0] KIND_RLC  = 5'd14;
  localparam logic [KIND_W-1:0] KIND_RRC  = 5'd15;
  localparam logic [KIND_W-1:0] KIND_RL   = 5'd16;
  localparam logic [KIND_W-1:0] KIND_RR   = 5'd17;

  // Flag bit positions
  localparam int FLAG_S  = 7;
  localparam int FLAG_Z  = 6;
  localparam int FLAG_Y  = 5;
  localparam int FLAG_H  = 4;
  localparam int FLAG_X  = 3;
  localparam int FLAG_PV = 2;
  localparam int FLAG_N  = 1;
  localparam int FLAG_C  = 0;

  localparam logic [DATA_W-1:0] INC_OVF_VAL = 8'h80;
  localparam logic [DATA_W-1:0] DEC_OVF_VAL = 8'h7F;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] accumulator;
    logic [DATA_W-1:0] operand;
    logic [DATA_W-1:0] flags_in;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic [DATA_W-1:0] flags_out;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/alu8f_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface alu8f_in_if;
  logic                            valid;
  logic                            ready;
  logic [alu8f_pkg::KIND_W-1:0]    kind;
  logic [alu8f_pkg::DATA_W-1:0]    accumulator;
  logic [alu8f_pkg::DATA_W-1:0]    operand;
  logic [alu8f_pkg::DATA_W-1:0]    flags_in;

  modport source (output valid, output kind, output accumulator, output operand,
                  output flags_in, input ready);
  modport sink   (input valid, input kind, input accumulator, input operand,
                  input flags_in, output ready);
endinterface

interface alu8f_out_if;
  logic                            valid;
  logic                            ready;
  logic [alu8f_pkg::DATA_W-1:0]    result;
  logic [alu8f_pkg::DATA_W-1:0]    flags_out;

  modport source (output valid, output result, output flags_out, input ready);
  modport sink   (input valid, input result, input flags_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/alu8f_core.sv
`timescale 1ns / 1ps
`default_nettype none

module alu8f_core (
  input  alu8f_pkg::in_item_t  item_i,
  output alu8f_pkg::out_item_t item_o
);

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] fin;
  logic       cin;
  logic       ci_add;
  logic       ci_sub;
  logic [8:0] sum9;
  logic [8:0] dif9;
  logic [4:0] hsum;
  logic [4:0] hdif;
  logic [7:0] inc_r;
  logic [7:0] dec_r;
  logic [7:0] rot_r;
  logic       rot_c;
  logic [7:0] logic_r;

  assign a      = item_i.accumulator;
  assign b      = item_i.operand;
  assign fin    = item_i.flags_in;
  assign cin    = fin[alu8f_pkg::FLAG_C];
  assign ci_add = (item_i.kind == alu8f_pkg::KIND_ADC) & cin;
  assign ci_sub = (item_i.kind == alu8f_pkg::KIND_SBC) & cin;

  assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, ci_add};
  assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, ci_sub};
  assign hsum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci_add};
  assign hdif  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci_sub};
  assign inc_r = b + 8'd1;
  assign dec_r = b - 8'd1;

  always_comb begin
    case (item_i.kind)
      alu8f_pkg::KIND_AND: logic_r = a & b;
      alu8f_pkg::KIND_OR:  logic_r = a | b;
      default:             logic_r = a ^ b;
    endcase
  end

  // Rotates: the A forms and the full-flag forms share one shifter
  always_comb begin
    case (item_i.kind)
      alu8f_pkg::KIND_RLCA, alu8f_pkg::KIND_RLC: begin
        rot_c = b[7];
        rot_r = {b[6:0], b[7]};
      end
      alu8f_pkg::KIND_RRCA, alu8f_pkg::KIND_RRC: begin
        rot_c = b[0];
        rot_r = {b[0], b[7:1]};
      end
      alu8f_pkg::KIND_RLA, alu8f_pkg::KIND_RL: begin
        rot_c = b[7];
        rot_r = {b[6:0], cin};
      end
      default: begin
        rot_c = b[0];
        rot_r = {cin, b[7:1]};
      end
    endcase
  end

  always_comb begin
    item_o.result    = a;
    item_o.flags_out = fin;
    case (item_i.kind)
      alu8f_pkg::KIND_ADD, alu8f_pkg::KIND_ADC: begin
        item_o.result    = sum9[7:0];
        item_o.flags_out = {sum9[7], (sum9[7:0] == 8'd0), fin[5], hsum[4], fin[3],
                            ((a[7] ^ sum9[7]) & (b[7] ^ sum9[7])), 1'b0, sum9[8]};
      end
      alu8f_pkg::KIND_SUB, alu8f_pkg::KIND_SBC, alu8f_pkg::KIND_CP: begin
        item_o.result    = (item_i.kind == alu8f_pkg::KIND_CP) ? a : dif9[7:0];
        item_o.flags_out = {dif9[7], (dif9[7:0] == 8'd0), fin[5], hdif[4], fin[3],
                            ((a[7] ^ b[7]) & (a[7] ^ dif9[7])), 1'b1, dif9[8]};
      end
      alu8f_pkg::KIND_AND, alu8f_pkg::KIND_OR, alu8f_pkg::KIND_XOR: begin
        item_o.result    = logic_r;
        item_o.flags_out = {logic_r[7], (logic_r == 8'd0), fin[5],
                            (item_i.kind == alu8f_pkg::KIND_AND), fin[3],
                            ~^logic_r, 1'b0, 1'b0};
      end
      alu8f_pkg::KIND_INC: begin
        item_o.result    = inc_r;
        item_o.flags_out = {inc_r[7], (inc_r == 8'd0), fin[5], (inc_r[3:0] == 4'h0),
                            fin[3], (inc_r == alu8f_pkg::INC_OVF_VAL), 1'b0, cin};
      end
      alu8f_pkg::KIND_DEC: begin
        item_o.result    = dec_r;
        item_o.flags_out = {dec_r[7], (dec_r == 8'd0), fin[5], (dec_r[3:0] == 4'hF),
                            fin[3], (dec_r == alu8f_pkg::DEC_OVF_VAL), 1'b1, cin};
      end
      alu8f_pkg::KIND_RLCA, alu8f_pkg::KIND_RRCA,
      alu8f_pkg::KIND_RLA, alu8f_pkg::KIND_RRA: begin
        // keep S, Z and P/V
        item_o.result    = rot_r;
        item_o.flags_out = {fin[7], fin[6], fin[5], 1'b0, fin[3], fin[2], 1'b0, rot_c};
      end
      alu8f_pkg::KIND_RLC, alu8f_pkg::KIND_RRC,
      alu8f_pkg::KIND_RL, alu8f_pkg::KIND_RR: begin
        item_o.result    = rot_r;
        item_o.flags_out = {rot_r[7], (rot_r == 8'd0), fin[5], 1'b0, fin[3],
                            ~^rot_r, 1'b0, rot_c};
      end
      default: begin
        // undefined codes: pass through as a no-op
        item_o.result    = a;
        item_o.flags_out = fin;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/eight_bit_alu_with_flags.sv
// Eight-bit ALU with S, Z, H, P/V, N and C flags.
//
// in_ch  : sink of operation items (kind, accumulator, operand, flags_in),
//          taken at a rising edge of clk where valid and ready are high.
// out_ch : source of result items (result, flags_out), same handshake.
//
// Two register stages: an input register holds the accepted item, the ALU
// logic sits between it and the result register. An accepted item passes from
// the input register through the ALU logic into the result register, and its
// result is offered on out_ch from there. One item is taken every cycle as
// long as the receiver keeps taking results: each stage refills in the same
// cycle that it drains.
//
// When out_ch stalls, the result register holds its item and the input
// register fills behind it; in_ch.ready then drops until the result is
// taken, so nothing is lost or repeated.
//
// Reset (rst_n low, synchronous) empties both stages. Bits 3 and 5 of the
// flag byte always travel through unchanged.
`timescale 1ns / 1ps
`default_nettype none

module eight_bit_alu_with_flags (
  input  logic        clk,
  input  logic        rst_n,
  alu8f_in_if.sink    in_ch,
  alu8f_out_if.source out_ch
);

  // Input stage
  logic                 s1_vld_r;
  logic                 s1_vld_nxt;
  alu8f_pkg::in_item_t  s1_item_r;

  // Result stage
  logic                 s2_vld_r;
  logic                 s2_vld_nxt;
  alu8f_pkg::out_item_t s2_item_r;

  alu8f_pkg::out_item_t alu_out;
  logic                 s2_load;
  logic                 s1_load;

  // Result stage can take a new item when empty or being drained this cycle
  assign s2_load = s1_vld_r && (!s2_vld_r || out_ch.ready);
  // Input stage frees up when empty or when its item moves on
  assign in_ch.ready = !s1_vld_r || !s2_vld_r || out_ch.ready;
  assign s1_load     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (s1_load) begin
      s1_vld_nxt = 1'b1;
    end else if (s2_load) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    s2_vld_nxt = s2_vld_r;
    if (s2_load) begin
      s2_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      s2_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // Payload registers: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r.kind        <= in_ch.kind;
      s1_item_r.accumulator <= in_ch.accumulator;
      s1_item_r.operand     <= in_ch.operand;
      s1_item_r.flags_in    <= in_ch.flags_in;
    end
    if (s2_load) begin
      s2_item_r <= alu_out;
    end
  end

  alu8f_core u_core (
    .item_i (s1_item_r),
    .item_o (alu_out)
  );

  assign out_ch.valid     = s2_vld_r;
  assign out_ch.result    = s2_item_r.result;
  assign out_ch.flags_out = s2_item_r.flags_out;

  // Input only stalls when both stages are full and the receiver holds off
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_vld_r && s2_vld_r && !out_ch.ready))
    else $error("input stalled with room in the pipeline");

  // An item leaving the input stage lands in the result stage
  a_advance_fills_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> s2_vld_r)
    else $error("result stage lost an item");

  // Compare returns the accumulator untouched
  a_cp_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && (s1_item_r.kind == alu8f_pkg::KIND_CP))
      |=> (s2_item_r.result == $past(s1_item_r.accumulator)))
    else $error("compare changed the accumulator");

  // Undocumented flag bits pass straight through
  a_xy_flags_pass: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> ((s2_item_r.flags_out[alu8f_pkg::FLAG_Y] ==
                  $past(s1_item_r.flags_in[alu8f_pkg::FLAG_Y])) &&
                 (s2_item_r.flags_out[alu8f_pkg::FLAG_X] ==
                  $past(s1_item_r.flags_in[alu8f_pkg::FLAG_X]))))
    else $error("flag bits 3 or 5 altered");

endmodule

`default_nettype wire

>>> verif/eight_bit_alu_with_flags_tb.sv
`timescale 1ns / 1ps

module eight_bit_alu_with_flags_tb;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 3;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int PHASE_ITEMS     = 290;
  localparam int NUM_PHASES      = 4;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 10;

  typedef logic [alu8f_pkg::KIND_W-1:0] kind_t;

  // One row of the directed table: the item, and optionally a result typed in by hand.
  typedef struct {
    alu8f_pkg::in_item_t  stim;
    bit                   fixed;
    alu8f_pkg::out_item_t want;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  alu8f_in_if  in_ch();
  alu8f_out_if out_ch();

  eight_bit_alu_with_flags i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dir_row_t             directed_ops[$];
  alu8f_pkg::out_item_t results_due[$];   // results of accepted items, oldest first
  alu8f_pkg::out_item_t offer_want;       // result of the item now offered on in_ch
  alu8f_pkg::out_item_t head_want;
  int        items_sent   = 0;
  int        results_seen = 0;
  int        mismatches   = 0;
  int        cycle_count  = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  bit        hold_off_tog  = 1'b0;
  bit        hold_off_seen = 1'b0;
  int        hold_off_left = 0;

  always #HALF_PERIOD clk = ~clk;

  // Compute the result and flag byte of one ALU operation.
  function automatic alu8f_pkg::out_item_t predict_alu(input alu8f_pkg::in_item_t it);
    logic [7:0] a, b, f, r, fo, keep;
    logic [8:0] wide;
    logic [4:0] half;
    logic       ci, cout, rot;
    alu8f_pkg::out_item_t o;
    a    = it.accumulator;
    b    = it.operand;
    f    = it.flags_in;
    keep = f & 8'h28;
    r    = a;
    fo   = f;
    rot  = 1'b0;
    cout = 1'b0;
    case (it.kind)
      alu8f_pkg::KIND_ADD, alu8f_pkg::KIND_ADC: begin
        ci   = (it.kind == alu8f_pkg::KIND_ADC) ? f[alu8f_pkg::FLAG_C] : 1'b0;
        wide = {1'b0, a} + {1'b0, b} + ci;
        half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + ci;
        r    = wide[7:0];
        fo   = keep;
        fo[alu8f_pkg::FLAG_S]  = r[7];
        fo[alu8f_pkg::FLAG_Z]  = (r == 8'h00);
        fo[alu8f_pkg::FLAG_H]  = half[4];
        fo[alu8f_pkg::FLAG_PV] = (a[7] ^ r[7]) & (b[7] ^ r[7]);
        fo[alu8f_pkg::FLAG_C]  = wide[8];
      end
      alu8f_pkg::KIND_SUB, alu8f_pkg::KIND_SBC, alu8f_pkg::KIND_CP: begin
        ci   = (it.kind == alu8f_pkg::KIND_SBC) ? f[alu8f_pkg::FLAG_C] : 1'b0;
        wide = {1'b0, a} - {1'b0, b} - ci;
        half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - ci;
        fo   = keep;
        fo[alu8f_pkg::FLAG_S]  = wide[7];
        fo[alu8f_pkg::FLAG_Z]  = (wide[7:0] == 8'h00);
        fo[alu8f_pkg::FLAG_H]  = half[4];
        fo[alu8f_pkg::FLAG_PV] = (a[7] ^ b[7]) & (a[7] ^ wide[7]);
        fo[alu8f_pkg::FLAG_N]  = 1'b1;
        fo[alu8f_pkg::FLAG_C]  = wide[8];
        r = (it.kind == alu8f_pkg::KIND_CP) ? a : wide[7:0];
      end
      alu8f_pkg::KIND_AND, alu8f_pkg::KIND_OR, alu8f_pkg::KIND_XOR: begin
        if (it.kind == alu8f_pkg::KIND_AND) r = a & b;
        else if (it.kind == alu8f_pkg::KIND_OR) r = a | b;
        else r = a ^ b;
        fo = keep;
        fo[alu8f_pkg::FLAG_S]  = r[7];
        fo[alu8f_pkg::FLAG_Z]  = (r == 8'h00);
        fo[alu8f_pkg::FLAG_PV] = ~^r;
        fo[alu8f_pkg::FLAG_H]  = (it.kind == alu8f_pkg::KIND_AND);
      end
      alu8f_pkg::KIND_INC: begin
        r  = b + 8'd1;
        fo = keep;
        fo[alu8f_pkg::FLAG_S]  = r[7];
        fo[alu8f_pkg::FLAG_Z]  = (r == 8'h00);
        fo[alu8f_pkg::FLAG_H]  = (r[3:0] == 4'h0);
        fo[alu8f_pkg::FLAG_PV] = (r == alu8f_pkg::INC_OVF_VAL);
        fo[alu8f_pkg::FLAG_C]  = f[alu8f_pkg::FLAG_C];
      end
      alu8f_pkg::KIND_DEC: begin
        r  = b - 8'd1;
        fo = keep;
        fo[alu8f_pkg::FLAG_S]  = r[7];
        fo[alu8f_pkg::FLAG_Z]  = (r == 8'h00);
        fo[alu8f_pkg::FLAG_H]  = (r[3:0] == 4'hF);
        fo[alu8f_pkg::FLAG_PV] = (r == alu8f_pkg::DEC_OVF_VAL);
        fo[alu8f_pkg::FLAG_N]  = 1'b1;
        fo[alu8f_pkg::FLAG_C]  = f[alu8f_pkg::FLAG_C];
      end
      alu8f_pkg::KIND_RLCA, alu8f_pkg::KIND_RLC: begin
        rot = 1'b1; cout = b[7]; r = {b[6:0], b[7]};
      end
      alu8f_pkg::KIND_RRCA, alu8f_pkg::KIND_RRC: begin
        rot = 1'b1; cout = b[0]; r = {b[0], b[7:1]};
      end
      alu8f_pkg::KIND_RLA, alu8f_pkg::KIND_RL: begin
        rot = 1'b1; cout = b[7]; r = {b[6:0], f[alu8f_pkg::FLAG_C]};
      end
      alu8f_pkg::KIND_RRA, alu8f_pkg::KIND_RR: begin
        rot = 1'b1; cout = b[0]; r = {f[alu8f_pkg::FLAG_C], b[7:1]};
      end
      default: begin
        // Undefined kinds pass accumulator and flags straight through.
        r  = a;
        fo = f;
      end
    endcase
    if (rot) begin
      if (it.kind <= alu8f_pkg::KIND_RRA) begin
        // Accumulator rotates keep S, Z and P/V.
        fo = f;
      end else begin
        fo = keep;
        fo[alu8f_pkg::FLAG_S]  = r[7];
        fo[alu8f_pkg::FLAG_Z]  = (r == 8'h00);
        fo[alu8f_pkg::FLAG_PV] = ~^r;
      end
      fo[alu8f_pkg::FLAG_H] = 1'b0;
      fo[alu8f_pkg::FLAG_N] = 1'b0;
      fo[alu8f_pkg::FLAG_C] = cout;
    end
    o.result    = r;
    o.flags_out = fo;
    return o;
  endfunction

  function automatic void add_row(input kind_t kind, input logic [7:0] acc,
                                  input logic [7:0] opnd, input logic [7:0] flg,
                                  input bit fixed, input logic [7:0] res,
                                  input logic [7:0] fl);
    dir_row_t row;
    row.stim.kind        = kind;
    row.stim.accumulator = acc;
    row.stim.operand     = opnd;
    row.stim.flags_in    = flg;
    row.fixed            = fixed;
    row.want.result      = res;
    row.want.flags_out   = fl;
    directed_ops.push_back(row);
  endfunction

  // Favor the byte values where carries, overflow and parity flip.
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [6];
    corners = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h0F, 8'h10};
    if ($urandom_range(3) == 0) return corners[3'($urandom_range(5))];
    return 8'($urandom_range(255));
  endfunction

  // Offer one item after a random gap; return at the edge where it is taken.
  task automatic offer_item(input alu8f_pkg::in_item_t stim,
                            input alu8f_pkg::out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= stim.kind;
    in_ch.accumulator <= stim.accumulator;
    in_ch.operand     <= stim.operand;
    in_ch.flags_in    <= stim.flags_in;
    offer_want        <= want;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Drop valid and hold until every accepted item has produced its result.
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  // Receiver: stall at random, or hold off for a long stretch when asked.
  always @(posedge clk) begin
    if (hold_off_tog != hold_off_seen) begin
      hold_off_seen <= hold_off_tog;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_ch.ready  <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each taken result against the oldest one due, then record newly taken items.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: result %h flags %h", out_ch.result,
                     out_ch.flags_out);
        end else begin
          head_want = results_due.pop_front();
          if (out_ch.result !== head_want.result ||
              out_ch.flags_out !== head_want.flags_out) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: result exp %h got %h, flags exp %h got %h",
                       head_want.result, out_ch.result,
                       head_want.flags_out, out_ch.flags_out);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) results_due.push_back(offer_want);
    end
  end

  // Bound the run in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    alu8f_pkg::in_item_t  stim;
    alu8f_pkg::out_item_t want;
    int        idle_pct [NUM_PHASES];
    int        stall_pct [NUM_PHASES];

    in_ch.valid       = 1'b0;
    in_ch.kind        = '0;
    in_ch.accumulator = '0;
    in_ch.operand     = '0;
    in_ch.flags_in    = '0;
    offer_want        = '0;

    // Directed rows: extremes of every operation, carry-in, overflow, and undefined kinds.
    add_row(alu8f_pkg::KIND_ADD,  8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h40);
    add_row(alu8f_pkg::KIND_ADD,  8'hFF, 8'h01, 8'h00, 1, 8'h00, 8'h51);
    add_row(alu8f_pkg::KIND_ADD,  8'h7F, 8'h01, 8'h00, 1, 8'h80, 8'h94);
    add_row(alu8f_pkg::KIND_ADC,  8'hFF, 8'hFF, 8'h01, 1, 8'hFF, 8'h91);
    add_row(alu8f_pkg::KIND_ADC,  8'h0F, 8'h00, 8'h29, 0, 8'h00, 8'h00);
    add_row(alu8f_pkg::KIND_SUB,  8'h00, 8'h01, 8'h00, 1, 8'hFF, 8'h93);
    add_row(alu8f_pkg::KIND_SUB,  8'h80, 8'h01, 8'h00, 1, 8'h7F, 8'h16);
    add_row(alu8f_pkg::KIND_SBC,  8'h00, 8'hFF, 8'h01, 1, 8'h00, 8'h53);
    add_row(alu8f_pkg::KIND_AND,  8'hFF, 8'hFF, 8'h00, 1, 8'hFF, 8'h94);
    add_row(alu8f_pkg::KIND_AND,  8'hAA, 8'h55, 8'hFF, 1, 8'h00, 8'h7C);
    add_row(alu8f_pkg::KIND_OR,   8'h01, 8'h00, 8'h00, 1, 8'h01, 8'h00);
    add_row(alu8f_pkg::KIND_XOR,  8'hFF, 8'hFF, 8'h28, 1, 8'h00, 8'h6C);
    add_row(alu8f_pkg::KIND_CP,   8'h10, 8'h10, 8'h00, 1, 8'h10, 8'h42);
    add_row(alu8f_pkg::KIND_INC,  8'h33, 8'h7F, 8'h01, 1, 8'h80, 8'h95);
    add_row(alu8f_pkg::KIND_INC,  8'h33, 8'hFF, 8'h00, 1, 8'h00, 8'h50);
    add_row(alu8f_pkg::KIND_DEC,  8'h33, 8'h80, 8'h00, 1, 8'h7F, 8'h16);
    add_row(alu8f_pkg::KIND_DEC,  8'h33, 8'h00, 8'h01, 1, 8'hFF, 8'h93);
    add_row(alu8f_pkg::KIND_RLCA, 8'h00, 8'h80, 8'hFF, 1, 8'h01, 8'hED);
    add_row(alu8f_pkg::KIND_RRCA, 8'h00, 8'h01, 8'h00, 0, 8'h00, 8'h00);
    add_row(alu8f_pkg::KIND_RLA,  8'h00, 8'h7F, 8'h01, 0, 8'h00, 8'h00);
    add_row(alu8f_pkg::KIND_RRA,  8'h00, 8'h00, 8'h01, 0, 8'h00, 8'h00);
    add_row(alu8f_pkg::KIND_RLC,  8'h00, 8'h81, 8'h00, 0, 8'h00, 8'h00);
    add_row(alu8f_pkg::KIND_RRC,  8'h00, 8'h00, 8'hFF, 1, 8'h00, 8'h6C);
    add_row(alu8f_pkg::KIND_RL,   8'h00, 8'h80, 8'h00, 0, 8'h00, 8'h00);
    add_row(alu8f_pkg::KIND_RR,   8'h00, 8'h01, 8'h01, 0, 8'h00, 8'h00);
    add_row(5'd18,                8'h00, 8'hFF, 8'h00, 1, 8'h00, 8'h00);
    add_row(5'd31,                8'hA5, 8'h5A, 8'hD7, 1, 8'hA5, 8'hD7);

    // Phases: no idling, sender idle, receiver stalling, both lightly.
    idle_pct  = '{0, 81, 0, 8};
    stall_pct = '{0, 0, 81, 8};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table back to back.
    foreach (directed_ops[i]) begin
      want = directed_ops[i].fixed ? directed_ops[i].want : predict_alu(directed_ops[i].stim);
      offer_item(directed_ops[i].stim, want);
    end
    wait_all_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct   = idle_pct[p];
      recv_stall_pct <= stall_pct[p];
      // Hold the receiver off at the start of the first phase so the block fills up.
      if (p == 0) hold_off_tog <= ~hold_off_tog;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(9) == 0) stim.kind = kind_t'($urandom_range(31, 18));
        else stim.kind = kind_t'($urandom_range(alu8f_pkg::KIND_RR));
        stim.accumulator = pick_byte();
        stim.operand     = pick_byte();
        stim.flags_in    = 8'($urandom_range(255));
        offer_item(stim, predict_alu(stim));
      end
      // Pause the sender until everything in flight has come out.
      wait_all_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/alu8f_pkg.sv
rtl/core/alu8f_if.sv
rtl/core/alu8f_core.sv
rtl/core/eight_bit_alu_with_flags.sv
verif/eight_bit_alu_with_flags_tb.sv
